### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ERS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ERS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

### hw/rtl/ers_pkg.sv
package ers_pkg;

    localparam int IDX_W  = 6;   // segment index field
    localparam int LEN_W  = 48;  // segment length and offsets
    localparam int RLEN_W = 25;  // request length and byte count
    localparam int CNT_W  = 7;   // segment_count register

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SPLIT = 1'b1;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_OVERRUN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_WALK,
        S_ERR
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0]  seg_idx;
        logic [LEN_W-1:0]  seg_off;
        logic [RLEN_W-1:0] byte_cnt;
        logic              status;
        logic              last;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LEN_W-1:0]  wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

### hw/rtl/ers_ram.sv
module ers_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ers_oreg.sv
module ers_oreg import ers_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_res,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_valid || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### hw/rtl/ers_seq.sv
module ers_seq import ers_pkg::*; #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [LEN_W-1:0]  entry_length,
    input  logic [LEN_W-1:0]  byte_offset,
    input  logic [RLEN_W-1:0] request_length,
    input  logic [CNT_W-1:0]  seg_count,
    output mem_req_t          mem_req,
    input  logic [LEN_W-1:0]  rdata,
    output logic              out_valid,
    input  logic              out_ready,
    output res_t              out_res
);

    localparam int CW    = $clog2(MAX_SEGMENTS + 1);
    localparam int TOT_W = LEN_W + $clog2(MAX_SEGMENTS) + 1;

    state_t state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [LEN_W-1:0]  off_reg, off_next;
    logic [RLEN_W-1:0] rem_reg, rem_next;
    logic [TOT_W-1:0]  total_reg, total_next;

    logic [CW-1:0]     n_used;
    logic [CW-1:0]     idx_inc;
    logic              accept;
    logic              start;
    logic              skip;
    logic              overrun;
    logic [LEN_W-1:0]  room;
    logic [RLEN_W-1:0] take;
    logic [RLEN_W-1:0] rem_after;

    assign n_used = (seg_count > CNT_W'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                       : seg_count[CW-1:0];
    assign idx_inc = idx_reg + CW'(1);
    assign accept  = in_valid && in_ready;
    assign start   = accept && (op == OP_SPLIT) && (request_length != '0);

    // Offset still past this entry: consume it whole (also drops empty segments).
    assign skip      = off_reg >= rdata;
    assign room      = rdata - off_reg;
    assign take      = (LEN_W'(rem_reg) < room) ? rem_reg : room[RLEN_W-1:0];
    assign rem_after = rem_reg - take;
    assign overrun   = (TOT_W'(off_reg) + TOT_W'(rem_reg)) > total_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = (n_used == '0) ? S_ERR : S_SUM;
                end
            end
            S_SUM: begin
                if (idx_inc == n_used) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = overrun ? S_ERR : S_WALK;
            end
            S_WALK: begin
                if (skip) begin
                    if (idx_inc == n_used) begin
                        state_next = S_IDLE;
                    end
                end else if (out_ready) begin
                    if (rem_after == '0 || idx_inc == n_used) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_res    = '0;
        mem_req    = '0;
        idx_next   = idx_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        unique case (state_reg)
            S_IDLE: begin
                in_ready      = 1'b1;
                mem_req.waddr = entry_index;
                mem_req.wdata = entry_length;
                if (accept && op == OP_LOAD) begin
                    mem_req.we = CNT_W'(entry_index) < CNT_W'(MAX_SEGMENTS);
                end
                if (start) begin
                    off_next   = byte_offset;
                    rem_next   = request_length;
                    total_next = '0;
                    idx_next   = '0;
                    mem_req.re = 1'b1;
                end
            end
            S_SUM: begin
                total_next    = total_reg + TOT_W'(rdata);
                mem_req.re    = 1'b1;
                mem_req.raddr = IDX_W'(idx_inc);
                idx_next      = idx_inc;
                if (idx_inc == n_used) begin
                    // entry 0 is re-read for the walk and held through the check
                    idx_next      = '0;
                    mem_req.raddr = '0;
                end
            end
            S_CHECK: begin
            end
            S_WALK: begin
                out_res.seg_idx  = IDX_W'(idx_reg);
                out_res.seg_off  = off_reg;
                out_res.byte_cnt = take;
                out_res.status   = STAT_OK;
                out_res.last     = (rem_after == '0);
                if (skip) begin
                    off_next      = off_reg - rdata;
                    idx_next      = idx_inc;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(idx_inc);
                end else begin
                    out_valid = 1'b1;
                    if (out_ready) begin
                        rem_next      = rem_after;
                        off_next      = '0;
                        idx_next      = idx_inc;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = IDX_W'(idx_inc);
                    end
                end
            end
            S_ERR: begin
                out_valid      = 1'b1;
                out_res.status = STAT_OVERRUN;
                out_res.last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        off_reg   <= off_next;
        rem_reg   <= rem_next;
        total_reg <= total_next;
    end

endmodule

### hw/rtl/extent_range_splitter.sv
// Splits a byte range over a table of up to MAX_SEGMENTS segment lengths laid end to end.
// A load request (tuser 0) writes one table entry. A split request (tuser 1) with nonzero
// length is accepted, sums the lengths of the segments in use (segment_count, capped at
// MAX_SEGMENTS), checks the range against the total, then walks the table entries up to the
// last segment the range touches, waiting while the result side stalls; no new request is
// taken until it is done. The length table has a single read port; the sum pass reads one
// entry a cycle, and the walk one entry a cycle while the result side does not stall.
// A range past the table total, or any nonzero-length split while segment_count is zero,
// gives a single result with status 1 and zero fields. Entries must be loaded before a
// split reads them.
module extent_range_splitter import ers_pkg::*; #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, entry_length, byte_offset, request_length, zero pad
    input  logic [127:0] s_tdata,
    // op
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // segment_index, segment_offset, byte_count, zero pad
    output logic [79:0]  m_tdata,
    // status
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data
);

    `include "assert_macros.svh"

    localparam int RAM_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    logic [CNT_W-1:0]  seg_count_reg, seg_count_next;
    logic [IDX_W-1:0]  entry_index;
    logic [LEN_W-1:0]  entry_length;
    logic [LEN_W-1:0]  byte_offset;
    logic [RLEN_W-1:0] request_length;
    mem_req_t          mem_req;
    logic [LEN_W-1:0]  rdata;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    res_t              m_res;

    assign cfg_ready      = 1'b1;
    assign seg_count_next = (cfg_valid && cfg_ready) ? cfg_data : seg_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_count_reg <= CNT_W'(1);
        end else begin
            seg_count_reg <= seg_count_next;
        end
    end

    assign entry_index    = s_tdata[5:0];
    assign entry_length   = s_tdata[53:6];
    assign byte_offset    = s_tdata[101:54];
    assign request_length = s_tdata[126:102];

    ers_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr[RAM_AW-1:0]),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr[RAM_AW-1:0]),
        .rdata (rdata)
    );

    ers_seq #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .op             (s_tuser[0]),
        .entry_index    (entry_index),
        .entry_length   (entry_length),
        .byte_offset    (byte_offset),
        .request_length (request_length),
        .seg_count      (seg_count_reg),
        .mem_req        (mem_req),
        .rdata          (rdata),
        .out_valid      (res_valid),
        .out_ready      (res_ready),
        .out_res        (res)
    );

    ers_oreg u_oreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (m_res)
    );

    assign m_tdata = {1'b0, m_res.byte_cnt, m_res.seg_off, m_res.seg_idx};
    assign m_tuser = m_res.status;
    assign m_tlast = m_res.last;

    `ERS_ASSERT(a_err_is_last, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> m_tlast,
                "error result without last")
    `ERS_ASSERT(a_err_zero, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0),
                "error result fields not zero")
    `ERS_ASSERT_NEVER(a_no_empty_piece, aclk, aresetn,
                      m_tvalid && !m_tuser[0] && (m_res.byte_cnt == '0),
                      "ok result with zero bytes")
    `ERS_ASSERT(a_busy_after_split, aclk, aresetn,
                (s_tvalid && s_tready && s_tuser[0] && (request_length != '0)) |=> !s_tready,
                "request taken while a split is in progress")

endmodule
